FILE: hdl/sebl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the bin lookup.
`timescale 1ns / 1ps
package sebl_pkg;

	localparam int MAX_EDGES  = 64;
	localparam int ADDR_W     = $clog2(MAX_EDGES);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int VALUE_W    = 32;
	localparam int EDGE_CNT_W = 7;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;

	localparam logic [EDGE_CNT_W-1:0] MIN_COUNT = EDGE_CNT_W'(2);
	localparam logic [EDGE_CNT_W-1:0] MAX_COUNT = EDGE_CNT_W'(MAX_EDGES);

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REJECT  = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic load;
		logic rd_prev;
		logic chk;
		logic commit;
		logic scan;
		logic emit;
	} sebl_cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic slot_zero;
		logic invalid;
		logic scan_last;
		logic out_free;
	} sebl_sts_t;

endpackage

FILE: hdl/sebl_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module sebl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/sebl_ctrl.sv
// Controller state machine that sequences edge writes and lookup scans.
`timescale 1ns / 1ps
module sebl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  sebl_pkg::sebl_sts_t sts,
	output sebl_pkg::sebl_cmd_t cmd
);
	import sebl_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_WREAD    = 3'd2;
	localparam logic [2:0] S_WCHK     = 3'd3;
	localparam logic [2:0] S_WCOMMIT  = 3'd4;
	localparam logic [2:0] S_SCAN     = 3'd5;
	localparam logic [2:0] S_DRAIN    = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_lookup) begin
					state_d = sts.invalid ? S_FIN : S_SCAN;
				end else begin
					state_d = sts.slot_zero ? S_WCOMMIT : S_WREAD;
				end
			end
			S_WREAD: begin
				cmd.rd_prev = 1'b1;
				state_d     = S_WCHK;
			end
			S_WCHK: begin
				cmd.chk = 1'b1;
				state_d = S_WCOMMIT;
			end
			S_WCOMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_FIN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last edge read comes back from memory in this cycle.
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

FILE: hdl/sebl_dp.sv
// Datapath: request registers, edge memory, scan counter, invalid flag and result register.
`timescale 1ns / 1ps
module sebl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sebl_pkg::sebl_cmd_t                  cmd,
	output sebl_pkg::sebl_sts_t                  sts,
	input  logic [sebl_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [sebl_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser,
	input  logic                                 cfg_we,
	input  logic [sebl_pkg::EDGE_CNT_W-1:0]      cfg_wdata
);
	import sebl_pkg::*;

	// Request fields held for the duration of one item.
	logic                  req_type_q;
	logic [ADDR_W-1:0]     slot_q;
	logic [VALUE_W-2:0]    value_q;
	logic [VALUE_W-1:0]    lag_q;

	logic [EDGE_CNT_W-1:0] edge_count_q;
	logic [EDGE_CNT_W-1:0] n_used;
	logic [ADDR_W-1:0]     last_idx;

	logic                  invalid_q;
	logic                  rej_q;
	logic                  range_bad_q;
	logic [ADDR_W-1:0]     idx_q;
	logic [CNT_W-1:0]      cnt_q;

	// Scan read in flight, delayed to line up with the registered read data.
	logic                  rd_vld_s1;
	logic                  rd_first_s1;
	logic                  rd_last_s1;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_addr;
	logic [VALUE_W-1:0]    ram_wdata;
	logic [VALUE_W-1:0]    ram_rdata;

	logic                  m_tvalid_q;
	logic [1:0]            res_status_q;
	logic [ADDR_W-1:0]     res_bin_q;

	logic [1:0]            fin_status;
	logic [ADDR_W-1:0]     fin_bin;
	logic                  edge_le_lag;

	always_comb begin
		if (edge_count_q < MIN_COUNT) begin
			n_used = MIN_COUNT;
		end else if (edge_count_q > MAX_COUNT) begin
			n_used = MAX_COUNT;
		end else begin
			n_used = edge_count_q;
		end
	end
	assign last_idx = ADDR_W'(n_used - EDGE_CNT_W'(1));

	always_comb begin
		ram_addr = idx_q;
		if (cmd.rd_prev) begin
			ram_addr = slot_q - ADDR_W'(1);
		end else if (cmd.commit) begin
			ram_addr = slot_q;
		end
	end
	assign ram_we    = cmd.commit && !rej_q;
	assign ram_wdata = {1'b0, value_q};

	sebl_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign edge_le_lag = ($signed(ram_rdata) <= $signed(lag_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= s_tuser;
			slot_q     <= s_tdata[ADDR_W-1:0];
			value_q    <= s_tdata[ADDR_W +: VALUE_W-1];
			lag_q      <= s_tdata[ADDR_W+VALUE_W-1 +: VALUE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= MIN_COUNT;
			invalid_q    <= 1'b0;
			rej_q        <= 1'b0;
			range_bad_q  <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_first_s1  <= 1'b0;
			rd_last_s1   <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				edge_count_q <= cfg_wdata;
			end

			rd_vld_s1   <= cmd.scan;
			rd_first_s1 <= cmd.scan && (idx_q == '0);
			rd_last_s1  <= cmd.scan && (idx_q == last_idx);

			if (cmd.load) begin
				rej_q       <= 1'b0;
				range_bad_q <= 1'b0;
				idx_q       <= '0;
				cnt_q       <= '0;
			end else begin
				if (cmd.chk) begin
					// An edge must lie strictly above the one in the slot below.
					rej_q <= !($signed({1'b0, value_q}) > $signed(ram_rdata));
				end
				if (cmd.scan) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				if (rd_vld_s1) begin
					if (edge_le_lag) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if ((rd_first_s1 && !edge_le_lag) || (rd_last_s1 && edge_le_lag)) begin
						range_bad_q <= 1'b1;
					end
				end
			end

			if (cmd.commit) begin
				if (rej_q) begin
					invalid_q <= 1'b1;
				end else if (slot_q == '0) begin
					invalid_q <= 1'b0;
				end
			end

			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		fin_status = ST_OK;
		fin_bin    = '0;
		if (req_type_q == REQ_WRITE) begin
			fin_status = rej_q ? ST_REJECT : ST_OK;
		end else if (invalid_q) begin
			fin_status = ST_INVALID;
		end else if (range_bad_q) begin
			fin_status = ST_RANGE;
		end else begin
			fin_bin = ADDR_W'(cnt_q - CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_status_q <= fin_status;
			res_bin_q    <= fin_bin;
		end
	end

	assign sts.is_lookup = (req_type_q == REQ_LOOKUP);
	assign sts.slot_zero = (slot_q == '0);
	assign sts.invalid   = invalid_q;
	assign sts.scan_last = (idx_q == last_idx);
	assign sts.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = OUT_DATA_W'(res_bin_q);

	// A result is only loaded when the output register is free or being emptied.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an untaken result");

	// A rejected write leaves the table marked invalid.
	a_reject_sets_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && rej_q) |=> invalid_q)
		else $error("rejected write did not set the invalid flag");

	// The scan never counts more edges than the table holds.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_EDGES))
		else $error("edge count overflowed");

	// A delivered bin index never exceeds the last bin of a full table.
	a_bin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (res_bin_q <= ADDR_W'(MAX_EDGES - 2)))
		else $error("bin index out of bounds");

endmodule

FILE: hdl/sorted_edge_bin_lookup.sv
// Top level of the sorted edge bin lookup: controller, datapath and ports.
//
// Usage: items enter on the s_ channel. s_tuser selects the request (0 writes
// an edge, 1 looks up a lag); s_tdata carries edge_slot, edge_value and lag.
// Each item yields exactly one result item on the m_ channel: m_tuser is the
// status (ok, edge rejected, lag out of range, table invalid) and m_tdata the
// bin index. cfg_we with cfg_wdata sets the number of edges in use while idle.
// A write goes from acceptance through dispatch, a read of the slot below,
// check, commit and finish to the result register (slot 0 skips the read and
// check); a lookup goes through dispatch, scan, drain and finish, or straight
// from dispatch to finish when the table is marked invalid. The lookup time is
// set by the scan that reads every edge in use from the single-port edge
// memory, one edge per cycle, so that the count of edges not above the lag is
// exact even for an unsorted table. One item is in work at a time; the next
// is taken once the result is in the output register, even while it waits.
// Reset clears the invalid flag, sets edge_count to 2 and empties the output;
// the edge memory is not cleared and holds no meaning until written.
// When the receiver stalls, the result holds in the output register and the
// next item stops before delivery until the register frees.
`timescale 1ns / 1ps
module sorted_edge_bin_lookup (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata: edge_slot[5:0], edge_value[36:6], lag[68:37], zeros[71:69]
	input  logic [sebl_pkg::IN_DATA_W-1:0]       s_tdata,
	// s_tuser: req_type
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata: bin_index[5:0], zeros[7:6]
	output logic [sebl_pkg::OUT_DATA_W-1:0]      m_tdata,
	// m_tuser: status[1:0]
	output logic [1:0]                           m_tuser,
	input  logic                                 cfg_we,
	input  logic [sebl_pkg::EDGE_CNT_W-1:0]      cfg_wdata
);
	import sebl_pkg::*;

	sebl_cmd_t cmd;
	sebl_sts_t sts;

	sebl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sebl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule
